>>> rtl/lcd_command_queue_4bit_writer_top_assert.svh
// assertion macros used by the lcd queue datapath
`ifndef LCD_COMMAND_QUEUE_4BIT_WRITER_TOP_ASSERT_SVH
`define LCD_COMMAND_QUEUE_4BIT_WRITER_TOP_ASSERT_SVH

// condition must hold on every clock edge out of reset
`define LCDQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LCDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LCDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lcdq_pkg.sv
// types, codes and tables of the lcd command queue
package lcdq_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_SEND    = 2'd1,
    OP_INIT    = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_FETCH,
    ST_EMIT,
    ST_RESP
  } state_e;

  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CMD_LINE_TWO  = 8'hC0;
  localparam logic [2:0] STEP_HI_END   = 3'd3;
  localparam logic [2:0] STEP_LAST     = 3'd7;

  typedef struct packed {
    logic       single;
    logic       rs;
    logic [7:0] code;
  } entry_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       rw;
    logic       enable;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       push;
    logic       push_init;
    logic       pop;
    logic       clear;
    logic       load_out;
    logic       out_pin;
    logic [2:0] step;
    logic [1:0] status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic single;
    logic can_load;
  } sts_t;

  // 4-bit start-up sequence, the first four send the high nibble only
  function automatic entry_t start_entry(input logic [2:0] idx);
    entry_t e;
    e.rs = 1'b0;
    case (idx)
      3'd0: begin e.code = 8'h30; e.single = 1'b1; end
      3'd1: begin e.code = 8'h30; e.single = 1'b1; end
      3'd2: begin e.code = 8'h30; e.single = 1'b1; end
      3'd3: begin e.code = 8'h20; e.single = 1'b1; end
      3'd4: begin e.code = 8'h28; e.single = 1'b0; end
      3'd5: begin e.code = 8'h0D; e.single = 1'b0; end
      3'd6: begin e.code = 8'h06; e.single = 1'b0; end
      default: begin e.code = 8'h01; e.single = 1'b0; end
    endcase
    return e;
  endfunction

  // pin state for one step of a send
  function automatic out_item_t pin_item(input logic [2:0] step, input entry_t e);
    out_item_t o;
    o.rw     = 1'b0;
    o.status = STAT_OK;
    o.last   = 1'b0;
    o.rs     = e.rs;
    o.enable = 1'b0;
    case (step)
      3'd0: o.nibble = e.code[7:4];
      3'd1: begin o.nibble = e.code[7:4]; o.enable = 1'b1; end
      3'd2: o.nibble = e.code[7:4];
      3'd3: o.nibble = 4'h0;
      3'd4: o.nibble = e.code[3:0];
      3'd5: begin o.nibble = e.code[3:0]; o.enable = 1'b1; end
      3'd6: o.nibble = e.code[3:0];
      default: begin o.nibble = 4'h0; o.rs = 1'b0; o.last = 1'b1; end
    endcase
    return o;
  endfunction

endpackage

>>> rtl/lcdq_stream_if.sv
// valid/ready channels for queue requests and pin-state results
interface lcdq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic [5:0] column_pos;
  logic [1:0] row_pos;
  logic       single_nibble;

  modport source (output valid, opcode, char_code, column_pos, row_pos, single_nibble,
                  input ready);
  modport sink   (input valid, opcode, char_code, column_pos, row_pos, single_nibble,
                  output ready);
endinterface

interface lcdq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] lcd_nibble;
  logic       lcd_rs;
  logic       lcd_rw;
  logic       lcd_enable;
  logic [1:0] status;
  logic       last;

  modport source (output valid, lcd_nibble, lcd_rs, lcd_rw, lcd_enable, status, last,
                  input ready);
  modport sink   (input valid, lcd_nibble, lcd_rs, lcd_rw, lcd_enable, status, last,
                  output ready);
endinterface

>>> rtl/lcdq_dpath.sv
// ring buffer of lcd transfers, pointers and the result register
`include "lcd_command_queue_4bit_writer_top_assert.svh"

module lcdq_dpath import lcdq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [7:0] char_code_i,
  input  logic [5:0] column_pos_i,
  input  logic [1:0] row_pos_i,
  input  logic       single_nibble_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] IDX_LAST  = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(QUEUE_DEPTH);

  entry_t        mem [QUEUE_DEPTH];
  entry_t        rdata_q;
  entry_t        user_entry;
  entry_t        wr_entry;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_item_q, out_item_d;
  out_item_t     resp_item;

  // byte to queue entry: newline or home position makes a command
  always_comb begin
    if (char_code_i == CHAR_NEWLINE) begin
      user_entry.code   = CMD_LINE_TWO;
      user_entry.rs     = 1'b0;
      user_entry.single = single_nibble_i;
    end else if (column_pos_i == 6'd0 && row_pos_i == 2'd0) begin
      user_entry.code   = char_code_i;
      user_entry.rs     = 1'b0;
      user_entry.single = single_nibble_i;
    end else begin
      user_entry.code   = char_code_i;
      user_entry.rs     = 1'b1;
      user_entry.single = 1'b0;
    end
  end

  assign wr_entry = cmd_i.push_init ? start_entry(cmd_i.step) : user_entry;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[tail_q] <= wr_entry;
    end
    if (cmd_i.pop) begin
      rdata_q <= mem[head_q];
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else begin
      if (cmd_i.push) begin
        tail_d  = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
        count_d = count_q + 1'b1;
      end
      if (cmd_i.pop) begin
        head_d  = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
      end
    end
  end

  always_comb begin
    resp_item        = '0;
    resp_item.status = cmd_i.status;
    resp_item.last   = 1'b1;
  end

  // result register frees up in the cycle its transfer completes
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      out_item_d  = cmd_i.out_pin ? pin_item(cmd_i.step, rdata_q) : resp_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign sts_o.full     = (count_q == CNT_FULL);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.single   = rdata_q.single;
  assign sts_o.can_load = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_item_q;

  `LCDQ_ASSERT_ALWAYS(a_count_range, count_q <= CNT_FULL, "entry count above depth")
  `LCDQ_ASSERT_IMPL(a_push_not_full, cmd_i.push && !cmd_i.clear, count_q != CNT_FULL,
    "push into full queue")
  `LCDQ_ASSERT_IMPL(a_pop_not_empty, cmd_i.pop, count_q != '0, "pop from empty queue")
  `LCDQ_ASSERT_IMPL(a_load_free, cmd_i.load_out, !out_valid_q || out_ready_i,
    "result overwritten before transfer")

endmodule

>>> rtl/lcdq_ctrl.sv
// sequencer for enqueue, init fill and send pin steps
module lcdq_ctrl import lcdq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] status_q, status_d;
  logic       accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    status_d = status_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          step_d   = '0;
          status_d = STAT_OK;
          state_d  = ST_RESP;
          case (opcode_i)
            OP_ENQUEUE: begin
              if (sts_i.full) status_d = STAT_FULL;
            end
            OP_SEND: begin
              if (sts_i.empty) status_d = STAT_EMPTY;
              else state_d = ST_FETCH;
            end
            OP_INIT: state_d = ST_FILL;
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_FILL: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) state_d = ST_RESP;
      end
      ST_FETCH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.can_load) begin
          if (step_q == STEP_LAST) begin
            state_d = ST_IDLE;
          end else if (step_q == STEP_HI_END && sts_i.single) begin
            step_d = STEP_LAST;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (sts_i.can_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.step   = step_q;
    cmd_o.status = status_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          case (opcode_i)
            OP_ENQUEUE: cmd_o.push  = !sts_i.full;
            OP_SEND:    cmd_o.pop   = !sts_i.empty;
            OP_INIT:    cmd_o.clear = 1'b1;
            default:    cmd_o.push  = 1'b0;
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.push      = 1'b1;
        cmd_o.push_init = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.load_out = sts_i.can_load;
        cmd_o.out_pin  = 1'b1;
      end
      ST_RESP: cmd_o.load_out = sts_i.can_load;
      default: cmd_o.load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      status_q <= STAT_OK;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      status_q <= status_d;
    end
  end

endmodule

>>> rtl/lcd_command_queue_4bit_writer_top.sv
// Character-LCD transfer queue with a 4-bit bus writer. One request is taken at a
// time. Enqueue and the unused opcode go through accept, then result, as does a
// send from an empty queue; init goes through accept, eight start-up entries
// written one per cycle through the single queue write port, then result; a send
// goes through accept, the registered queue read, then 8 pin states for a
// two-nibble entry or 5 for a single-nibble one, one pin state per cycle unless the
// result channel stalls; a stalled result channel stretches each of these.
// The queue holds QUEUE_DEPTH entries; its storage needs no clearing after reset.
module lcd_command_queue_4bit_writer_top import lcdq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  lcdq_in_if.sink      in_i,
  lcdq_out_if.source   out_o
);

  cmd_t      cmd;
  sts_t      sts;
  out_item_t item;

  lcdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .opcode_i   (in_i.opcode),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcdq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .char_code_i     (in_i.char_code),
    .column_pos_i    (in_i.column_pos),
    .row_pos_i       (in_i.row_pos),
    .single_nibble_i (in_i.single_nibble),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_item_o      (item)
  );

  assign out_o.lcd_nibble = item.nibble;
  assign out_o.lcd_rs     = item.rs;
  assign out_o.lcd_rw     = item.rw;
  assign out_o.lcd_enable = item.enable;
  assign out_o.status     = item.status;
  assign out_o.last       = item.last;

endmodule
